>>> src/gruf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gruf_pkg
// Shared sizes, command codes and control types of the glyph run fill decoder.
// ----------------------------------------------------------------------------
package gruf_pkg;

    localparam int MAX_WIDTH  = 16;   // bitmap columns, one bit per column
    localparam int MAX_HEIGHT = 16;   // bitmap rows

    localparam int MODE_W   = 2;
    localparam int START_W  = 4;
    localparam int LENGTH_W = 5;
    localparam int SELECT_W = 4;
    localparam int LINE_W   = 4;
    localparam int SIZE_W   = 5;
    localparam int END_W    = 6;      // start plus length without overflow
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [MODE_W-1:0] MODE_FILL    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NEWLINE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 2'd1;

    localparam logic [SIZE_W-1:0] SIZE_MAX_W = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] SIZE_MAX_H = SIZE_W'(MAX_HEIGHT);

    // Command from the controller to the datapath
    typedef struct packed {
        logic              fire;
        logic [MODE_W-1:0] mode;
        logic              direction;
        logic [LINE_W-1:0] line;
    } dp_cmd_t;

    // Status from the datapath back to the controller
    typedef struct packed {
        logic edge_reached;   // fill run reaches the glyph edge
        logic line_last;      // advancing wraps to the other direction
    } dp_stat_t;

    // Register value 0 acts as 1, values above the maximum act as the maximum
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                  input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [MAX_WIDTH-1:0] col_mask(input logic [END_W-1:0] n);
        logic [MAX_WIDTH-1:0] m;
        for (int i = 0; i < MAX_WIDTH; i++)
            m[i] = (END_W'(i) < n);
        return m;
    endfunction

    function automatic logic [MAX_HEIGHT-1:0] row_mask(input logic [END_W-1:0] n);
        logic [MAX_HEIGHT-1:0] m;
        for (int i = 0; i < MAX_HEIGHT; i++)
            m[i] = (END_W'(i) < n);
        return m;
    endfunction

endpackage

>>> src/gruf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gruf_if
// Valid/ready channels of the decoder: command, result and register write.
// ----------------------------------------------------------------------------
interface gruf_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [gruf_pkg::MODE_W-1:0]   mode;
    logic [gruf_pkg::START_W-1:0]  run_start;
    logic [gruf_pkg::LENGTH_W-1:0] run_length;
    logic [gruf_pkg::SELECT_W-1:0] row_select;

    modport source (output valid, mode, run_start, run_length, row_select, input ready);
    modport sink   (input valid, mode, run_start, run_length, row_select, output ready);
endinterface

interface gruf_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [gruf_pkg::MAX_WIDTH-1:0] row_bits;
    logic                           vertical_phase;
    logic [gruf_pkg::LINE_W-1:0]    line_index;

    modport source (output valid, row_bits, vertical_phase, line_index, input ready);
    modport sink   (input valid, row_bits, vertical_phase, line_index, output ready);
endinterface

interface gruf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gruf_pkg::CFG_IDX_W-1:0]  index;
    logic [gruf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/gruf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gruf_ctrl
// Controller: handshakes, direction and line index, datapath commands.
// ----------------------------------------------------------------------------
module gruf_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [gruf_pkg::MODE_W-1:0] in_mode,
    output logic                        out_valid,
    input  logic                        out_ready,
    output gruf_pkg::dp_cmd_t           cmd,
    input  gruf_pkg::dp_stat_t          stat,
    output logic                        direction,
    output logic [gruf_pkg::LINE_W-1:0] line
);
    import gruf_pkg::*;

    localparam logic ST_EMPTY = 1'b0;
    localparam logic ST_FULL  = 1'b1;

    logic              state_reg, state_next;
    logic              dir_reg, dir_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic              fire;
    logic              do_advance;

    // Accept while the result slot is empty or being emptied this cycle
    assign in_ready = (state_reg == ST_EMPTY) || out_ready;
    assign fire     = in_valid && in_ready;

    assign cmd.fire      = fire;
    assign cmd.mode      = in_mode;
    assign cmd.direction = dir_reg;
    assign cmd.line      = line_reg;

    always_comb
    begin
        unique case (in_mode)
            MODE_FILL:    do_advance = stat.edge_reached;
            MODE_NEWLINE: do_advance = 1'b1;
            default:      do_advance = 1'b0;
        endcase
    end

    always_comb
    begin
        dir_next  = dir_reg;
        line_next = line_reg;
        if (fire)
        begin
            if (in_mode == MODE_CLEAR)
            begin
                dir_next  = 1'b0;
                line_next = '0;
            end
            else if (do_advance)
            begin
                if (stat.line_last)
                begin
                    dir_next  = ~dir_reg;
                    line_next = '0;
                end
                else
                begin
                    line_next = line_reg + LINE_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        unique case (state_reg)
            ST_EMPTY: state_next = fire ? ST_FULL : ST_EMPTY;
            ST_FULL:  state_next = (fire || !out_ready) ? ST_FULL : ST_EMPTY;
            default:  state_next = ST_EMPTY;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
            dir_reg   <= 1'b0;
            line_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dir_reg   <= dir_next;
            line_reg  <= line_next;
        end
    end

    assign out_valid = (state_reg == ST_FULL);
    assign direction = dir_reg;
    assign line      = line_reg;

endmodule

>>> src/gruf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gruf_dp
// Datapath: size registers, pixel bitmap, run masks and row read register.
// ----------------------------------------------------------------------------
module gruf_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  gruf_pkg::dp_cmd_t               cmd,
    output gruf_pkg::dp_stat_t              stat,
    input  logic [gruf_pkg::START_W-1:0]    run_start,
    input  logic [gruf_pkg::LENGTH_W-1:0]   run_length,
    input  logic [gruf_pkg::SELECT_W-1:0]   row_select,
    input  logic                            cfg_we,
    input  logic [gruf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gruf_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [gruf_pkg::MAX_WIDTH-1:0]  row_bits
);
    import gruf_pkg::*;

    logic [SIZE_W-1:0]    width_reg, height_reg;
    logic [SIZE_W-1:0]    w_eff, h_eff, limit;
    logic [END_W-1:0]     run_end, stop_col, stop_row;
    logic [MAX_WIDTH-1:0] hmask;
    logic [MAX_HEIGHT-1:0] vmask;
    logic                 line_in_h, line_in_w;
    logic [MAX_WIDTH-1:0] pixel_reg [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0] read_word;
    logic [MAX_WIDTH-1:0] row_bits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_MAX_W;
            height_reg <= SIZE_MAX_H;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_GLYPH_WIDTH)
                width_reg <= SIZE_W'(cfg_data);
            else if (cfg_index == CFG_GLYPH_HEIGHT)
                height_reg <= SIZE_W'(cfg_data);
        end
    end

    assign w_eff = eff_size(width_reg, SIZE_MAX_W);
    assign h_eff = eff_size(height_reg, SIZE_MAX_H);

    assign run_end  = END_W'(run_start) + END_W'(run_length);
    assign stop_col = (run_end < END_W'(w_eff)) ? run_end : END_W'(w_eff);
    assign stop_row = (run_end < END_W'(h_eff)) ? run_end : END_W'(h_eff);
    assign hmask    = col_mask(stop_col) & ~col_mask(END_W'(run_start));
    assign vmask    = row_mask(stop_row) & ~row_mask(END_W'(run_start));

    // Lines left behind by a size change take no pixels
    assign line_in_h = SIZE_W'(cmd.line) < h_eff;
    assign line_in_w = SIZE_W'(cmd.line) < w_eff;

    assign limit             = cmd.direction ? w_eff : h_eff;
    assign stat.line_last    = (SIZE_W'(cmd.line) + SIZE_W'(1)) >= limit;
    assign stat.edge_reached = cmd.direction ? (run_end >= END_W'(h_eff))
                                             : (run_end >= END_W'(w_eff));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MAX_HEIGHT; r++)
                pixel_reg[r] <= '0;
        end
        else if (cmd.fire)
        begin
            for (int r = 0; r < MAX_HEIGHT; r++)
            begin
                if (cmd.mode == MODE_CLEAR)
                    pixel_reg[r] <= '0;
                else if (cmd.mode == MODE_FILL)
                begin
                    if (!cmd.direction && line_in_h && (cmd.line == LINE_W'(r)))
                        pixel_reg[r] <= pixel_reg[r] | hmask;
                    else if (cmd.direction && line_in_w && vmask[r])
                        pixel_reg[r] <= pixel_reg[r] | (MAX_WIDTH'(1) << cmd.line);
                end
            end
        end
    end

    assign read_word = (SIZE_W'(row_select) < h_eff)
                     ? (pixel_reg[row_select] & col_mask(END_W'(w_eff))) : '0;

    // Load the result word on every beat; only a read returns pixels
    always_ff @(posedge clk)
    begin
        if (cmd.fire)
            row_bits_reg <= (cmd.mode == MODE_READ) ? read_word : '0;
    end

    assign row_bits = row_bits_reg;

endmodule

>>> src/glyph_run_fill_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_run_fill_decoder_unit
// Rebuilds a 16x16 glyph bitmap from fill, newline, read and clear commands.
// ----------------------------------------------------------------------------
//  channel  role  payload                                    beat
//  cmd      sink  mode, run_start, run_length, row_select    valid & ready
//  rsp      src   row_bits, vertical_phase, line_index       valid & ready
//  cfg      sink  index (0 width, 1 height), data            valid & ready
//
//  A fill ORs a whole run mask into the flop bitmap, so a new beat is
//  taken every cycle while cmd.ready is high.
//  The result appears the cycle after its command beat and holds until taken;
//  cmd.ready drops only while a result waits and rsp.ready is low.
//  Reset clears the bitmap, direction and line at once and sets both sizes
//  to 16; cfg.ready is always high.
// ----------------------------------------------------------------------------
module glyph_run_fill_decoder_unit (
    input logic     clk,
    input logic     rst_n,
    gruf_cmd_if.sink   cmd,
    gruf_rsp_if.source rsp,
    gruf_cfg_if.sink   cfg
);
    import gruf_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;
    logic     cfg_we;

    // Register writes must arrive only while idle, which the block does not enforce; it takes them at once
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;

    // Controller owns the handshakes and the direction/line state
    gruf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .in_mode   (cmd.mode),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .direction (rsp.vertical_phase),
        .line      (rsp.line_index)
    );

    // Datapath holds the bitmap, the sizes and the read word
    gruf_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .run_start  (cmd.run_start),
        .run_length (cmd.run_length),
        .row_select (cmd.row_select),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .row_bits   (rsp.row_bits)
    );

    // Every accepted beat leaves a result behind
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> rsp.valid)
        else $error("no result after an accepted command");

    // Clear returns to row zero of the horizontal phase
    a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && cmd.mode == MODE_CLEAR)
        |=> (!rsp.vertical_phase && rsp.line_index == '0 && rsp.row_bits == '0))
        else $error("clear did not reset direction and line");

    // A stalled result must not see its state move under it
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready)
        |=> ($stable(rsp.line_index) && $stable(rsp.vertical_phase)))
        else $error("line state moved while result stalled");

    // An empty result slot never blocks a command
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp.valid |-> cmd.ready)
        else $error("command stalled with no pending result");

endmodule
